// ----- sv/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared constants and types for the Mandelbrot escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

  // Default field widths
  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_ITER_WIDTH  = 12;

  // Integer bits of the fixed-point coordinate format (Q4.x)
  localparam int INT_BITS = 4;

  // Reset value of the iteration limit register
  localparam int MAX_ITER_RESET = 64;

  // Entries in the queue between classifier and iteration engine
  localparam int QUEUE_DEPTH = 2;

  // Register port geometry
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register indexes
  localparam logic [0:0] REG_MAX_ITER = 1'b0;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ----- sv/mbe_mulq.sv -----
// ----------------------------------------------------------------------------
// mbe_mulq
// Signed fixed-point multiply, floored back to the working fraction width.
// ----------------------------------------------------------------------------
module mbe_mulq #(
  parameter int IN_W  = mbe_pkg::DEF_COORD_WIDTH + 2,
  parameter int SHIFT = mbe_pkg::DEF_COORD_WIDTH - mbe_pkg::INT_BITS,
  parameter int OUT_W = mbe_pkg::DEF_COORD_WIDTH + 5
) (
  input  logic signed [IN_W-1:0]  a_i,
  input  logic signed [IN_W-1:0]  b_i,
  output logic signed [OUT_W-1:0] p_o
);

  logic signed [2*IN_W-1:0] full;

  assign full = a_i * b_i;
  // dropping low bits of a two's complement product floors toward minus infinity
  assign p_o  = full[SHIFT +: OUT_W];

endmodule

// ----- sv/mbe_front.sv -----
// ----------------------------------------------------------------------------
// mbe_front
// Request intake and interior classification (cardioid and two bulbs).
// ----------------------------------------------------------------------------
module mbe_front #(
  parameter int COORD_WIDTH = mbe_pkg::DEF_COORD_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic signed [COORD_WIDTH-1:0] c_re_i,
  input  logic signed [COORD_WIDTH-1:0] c_im_i,
  input  mbe_pkg::queue_stat_t       qstat_i,
  output logic                       push_o,
  output logic [2*COORD_WIDTH:0]     push_data_o
);

  localparam int F   = COORD_WIDTH - mbe_pkg::INT_BITS;
  localparam int OPW = COORD_WIDTH + 2;
  localparam int PW  = COORD_WIDTH + 5;

  localparam logic signed [OPW-1:0] ONE     = OPW'(1) << F;
  localparam logic signed [OPW-1:0] QUARTER = ONE >>> 2;
  localparam logic signed [OPW-1:0] C_B2    = OPW'(21) * (ONE >>> 4);
  localparam logic signed [PW-1:0]  FOUR_P  = PW'(4) << F;
  localparam logic signed [PW:0]    ONE_S   = (PW+1)'(1) << F;
  localparam logic signed [PW:0]    B1_LIM  = ONE_S >>> 4;
  localparam logic signed [PW:0]    B2_LIM  = ONE_S >>> 8;

  typedef enum logic [2:0] {
    ST_IDLE, ST_YSQ, ST_XM, ST_B1, ST_B2, ST_CARD, ST_CMP, ST_PUSH
  } state_e;

  state_e                        state_q;
  logic                          inside_q;
  logic signed [COORD_WIDTH-1:0] cre_q, cim_q;
  logic signed [OPW-1:0]         x_ext, y_ext, xm, b1, b2, q_op, qxm_op;
  logic signed [OPW-1:0]         mul_a, mul_b;
  logic signed [PW-1:0]          prod, prod_q, ysq_q, q_q;
  logic signed [PW:0]            sq_sum;
  logic                          card_hit;

  assign x_ext  = OPW'(cre_q);
  assign y_ext  = OPW'(cim_q);
  assign xm     = x_ext - QUARTER;
  assign b1     = x_ext + ONE;
  assign b2     = x_ext + C_B2;
  // wraps only when q >= 32, where the cardioid test is already out
  assign q_op   = q_q[OPW-1:0];
  assign qxm_op = q_op + xm;

  assign sq_sum   = (PW+1)'(prod_q) + (PW+1)'(ysq_q);
  assign card_hit = (q_q < FOUR_P) && (prod_q < (ysq_q >>> 2));

  always_comb begin
    unique case (state_q)
      ST_XM:   begin mul_a = xm;   mul_b = xm;     end
      ST_B1:   begin mul_a = b1;   mul_b = b1;     end
      ST_B2:   begin mul_a = b2;   mul_b = b2;     end
      ST_CARD: begin mul_a = q_op; mul_b = qxm_op; end
      default: begin mul_a = y_ext; mul_b = y_ext; end
    endcase
  end

  mbe_mulq #(.IN_W(OPW), .SHIFT(F), .OUT_W(PW)) u_mul (
    .a_i(mul_a),
    .b_i(mul_b),
    .p_o(prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      inside_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q  <= ST_YSQ;
            inside_q <= 1'b0;
          end
        end
        ST_YSQ:  state_q <= ST_XM;
        ST_XM:   state_q <= ST_B1;
        ST_B1:   state_q <= ST_B2;
        ST_B2: begin
          inside_q <= (sq_sum < B1_LIM);
          state_q  <= ST_CARD;
        end
        ST_CARD: begin
          if (sq_sum < B2_LIM) inside_q <= 1'b1;
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (card_hit) inside_q <= 1'b1;
          state_q <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!qstat_i.full) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    if (state_q == ST_IDLE && start_i) begin
      cre_q <= c_re_i;
      cim_q <= c_im_i;
    end
    if (state_q == ST_XM) ysq_q <= prod_q;
    if (state_q == ST_B1) q_q   <= sq_sum[PW-1:0];
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign push_o      = (state_q == ST_PUSH) && !qstat_i.full;
  assign push_data_o = {inside_q, cre_q, cim_q};

endmodule

// ----- sv/mbe_queue.sv -----
// ----------------------------------------------------------------------------
// mbe_queue
// Short first-in first-out queue of classified points.
// ----------------------------------------------------------------------------
module mbe_queue #(
  parameter int DATA_W = 2 * mbe_pkg::DEF_COORD_WIDTH + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [DATA_W-1:0]    push_data_i,
  input  logic                 pop_i,
  output logic [DATA_W-1:0]    pop_data_o,
  output mbe_pkg::queue_stat_t qstat_o
);

  localparam int DEPTH = mbe_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              wr, rd;

  assign qstat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign wr            = push_i && !qstat_o.full;
  assign rd            = pop_i && !qstat_o.empty;
  assign pop_data_o    = slot_q[rd_ptr_q];

  always_comb begin
    unique case ({wr, rd})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (rd) rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ----- sv/mbe_back.sv -----
// ----------------------------------------------------------------------------
// mbe_back
// Iteration engine: z = z*z + c, one step per cycle, until escape or limit.
// ----------------------------------------------------------------------------
module mbe_back #(
  parameter int COORD_WIDTH = mbe_pkg::DEF_COORD_WIDTH,
  parameter int ITER_WIDTH  = mbe_pkg::DEF_ITER_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mbe_pkg::queue_stat_t       qstat_i,
  output logic                       pop_o,
  input  logic [2*COORD_WIDTH:0]     pop_data_i,
  input  logic [ITER_WIDTH-1:0]      limit_i,
  output logic                       done_o,
  output logic [ITER_WIDTH-1:0]      escape_count_o
);

  localparam int F   = COORD_WIDTH - mbe_pkg::INT_BITS;
  localparam int OPW = COORD_WIDTH + 2;
  localparam int PW  = COORD_WIDTH + 5;

  localparam logic signed [PW:0] FOUR_S = (PW+1)'(4) << F;

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  state_e                        state_q;
  logic                          done_q;
  logic [ITER_WIDTH-1:0]         count_q, n_q;
  logic signed [OPW-1:0]         x_q, y_q, x_d, y_d;
  logic signed [COORD_WIDTH-1:0] cx_q, cy_q, pop_cre, pop_cim;
  logic                          pop_inside;
  logic signed [PW-1:0]          xx, yy, xy2, ny;
  logic signed [PW:0]            mag, nx;
  logic                          escape;

  assign pop_inside = pop_data_i[2*COORD_WIDTH];
  assign pop_cre    = $signed(pop_data_i[2*COORD_WIDTH-1:COORD_WIDTH]);
  assign pop_cim    = $signed(pop_data_i[COORD_WIDTH-1:0]);
  assign pop_o      = (state_q == ST_IDLE) && !qstat_i.empty;

  mbe_mulq #(.IN_W(OPW), .SHIFT(F), .OUT_W(PW)) u_xx (
    .a_i(x_q), .b_i(x_q), .p_o(xx)
  );
  mbe_mulq #(.IN_W(OPW), .SHIFT(F), .OUT_W(PW)) u_yy (
    .a_i(y_q), .b_i(y_q), .p_o(yy)
  );
  // one fraction bit less gives floor(2xy)
  mbe_mulq #(.IN_W(OPW), .SHIFT(F - 1), .OUT_W(PW)) u_xy (
    .a_i(x_q), .b_i(y_q), .p_o(xy2)
  );

  assign mag    = (PW+1)'(xx) + (PW+1)'(yy);
  assign escape = (n_q >= limit_i) || (mag > FOUR_S);
  assign nx     = (PW+1)'(xx) - (PW+1)'(yy) + (PW+1)'(cx_q);
  assign ny     = xy2 + PW'(cy_q);
  // stay in range whenever the step is taken (|z|^2 <= 4)
  assign x_d    = nx[OPW-1:0];
  assign y_d    = ny[OPW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (!qstat_i.empty && pop_inside) begin
            done_q  <= 1'b1;
            count_q <= limit_i;
          end else begin
            done_q <= 1'b0;
            if (!qstat_i.empty) state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          done_q <= escape;
          if (escape) begin
            count_q <= n_q;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && !pop_inside) begin
      x_q  <= OPW'(pop_cre);
      y_q  <= OPW'(pop_cim);
      cx_q <= pop_cre;
      cy_q <= pop_cim;
      n_q  <= '0;
    end else if (state_q == ST_RUN && !escape) begin
      x_q <= x_d;
      y_q <= y_d;
      n_q <= n_q + 1'b1;
    end
  end

  assign done_o         = done_q;
  assign escape_count_o = count_q;

endmodule

// ----- sv/mandelbrot_escape_time.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape count of one complex point, with cardioid and bulb shortcuts.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+--------------------------
//   request  | in        | start high, busy low       | c_re_i, c_im_i (signed Q4.x)
//   result   | out       | done_o, one-cycle strobe   | escape_count_o
//   register | in/out    | psel, penable, pwrite      | paddr, pwdata, prdata
//
// The classifier is busy from an accepted request until its PUSH state ends,
// so it takes one request at a time; busy also holds while the queue is full.
// The iteration engine runs one step of z = z*z + c per cycle through three
// parallel multipliers until the point escapes or max_iterations steps are
// done; a cardioid/bulb hit returns max_iterations without iterating.
// A two-entry queue lets classification of the next request overlap
// iteration of the current one. Results cannot be stalled by the receiver.
// Reset (rst_ni low) empties the pipeline and sets max_iterations to 64.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time #(
  parameter int COORD_WIDTH = mbe_pkg::DEF_COORD_WIDTH,
  parameter int ITER_WIDTH  = mbe_pkg::DEF_ITER_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       c_re_i,
  input  logic signed [COORD_WIDTH-1:0]       c_im_i,
  // result
  output logic                                done_o,
  output logic [ITER_WIDTH-1:0]               escape_count_o,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mbe_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [mbe_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [mbe_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int DW      = mbe_pkg::APB_DATA_W;
  localparam int ENTRY_W = 2 * COORD_WIDTH + 1;

  logic [ITER_WIDTH-1:0] max_iter_q;
  logic                  reg_hit;
  logic                  push, pop;
  logic [ENTRY_W-1:0]    push_data, pop_data;
  mbe_pkg::queue_stat_t  qstat;

  // Register port: zero wait states; decode on the word index only.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[mbe_pkg::APB_ADDR_W-1:2] == mbe_pkg::REG_MAX_ITER);
  assign prdata  = reg_hit ? DW'(max_iter_q) : '0;

  // Take the limit on the access phase of a write; keep only the low bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= ITER_WIDTH'(mbe_pkg::MAX_ITER_RESET);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_iter_q <= pwdata[ITER_WIDTH-1:0];
    end
  end

  // Front: accept the request and run the three interior tests.
  mbe_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .c_re_i      (c_re_i),
    .c_im_i      (c_im_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue: hold classified points until the engine is free.
  mbe_queue #(.DATA_W(ENTRY_W)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .qstat_o     (qstat)
  );

  // Back: iterate, or return the limit at once for interior points.
  mbe_back #(.COORD_WIDTH(COORD_WIDTH), .ITER_WIDTH(ITER_WIDTH)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .qstat_i        (qstat),
    .pop_o          (pop),
    .pop_data_i     (pop_data),
    .limit_i        (max_iter_q),
    .done_o         (done_o),
    .escape_count_o (escape_count_o)
  );

endmodule

// ----- sv/mbe_checker.sv -----
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks on request and result ordering, bound to the top level.
// ----------------------------------------------------------------------------
module mbe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_i,
  input logic done_i
);

  // front holds one, queue holds its depth, engine holds one
  localparam int CAP = mbe_pkg::QUEUE_DEPTH + 2;
  localparam int PW  = $clog2(CAP + 2);

  logic          accept;
  logic [PW-1:0] pending_q, pending_d;

  assign accept = start_i && !busy_i;

  always_comb begin
    pending_d = pending_q;
    if (accept && !done_i) pending_d = pending_q + 1'b1;
    if (!accept && done_i) pending_d = pending_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_i)
    else $error("busy not raised after an accepted request");

  a_busy_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_i) |=> busy_i)
    else $error("classification finished too early");

  // reset has been seen by at least one edge before the strobe is judged
  a_no_done_in_reset: assert property (@(posedge clk_i)
    (!rst_ni && $past(!rst_ni)) |-> !done_i)
    else $error("result strobe during reset");

  a_done_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> (pending_q != '0))
    else $error("result without an outstanding request");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= PW'(CAP))
    else $error("more requests in flight than the pipeline can hold");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start),
  .busy_i  (busy),
  .done_i  (done_o)
);
